/* rtl/ppsp_pkg.sv */
// Package: phases, token and error codes, queue entry type for the probe packet parser.
package ppsp_pkg;

    typedef enum logic [4:0] {
        PH_PREFIX  = 5'd0,
        PH_HDR     = 5'd1,
        PH_SEQ_R   = 5'd2,
        PH_CTX_R   = 5'd3,
        PH_LEN0    = 5'd4,
        PH_STR0    = 5'd5,
        PH_LEN1    = 5'd6,
        PH_STR1    = 5'd7,
        PH_LEN2    = 5'd8,
        PH_STR2    = 5'd9,
        PH_FT_R    = 5'd10,
        PH_PS_R    = 5'd11,
        PH_PAY     = 5'd12,
        PH_SEQ_A   = 5'd13,
        PH_CTX_A   = 5'd14,
        PH_SRX     = 5'd15,
        PH_STX     = 5'd16,
        PH_FT_A    = 5'd17,
        PH_PS_A    = 5'd18,
        PH_ACC     = 5'd19,
        PH_LEN3    = 5'd20,
        PH_STR3    = 5'd21,
        PH_DONE    = 5'd22,
        PH_DISCARD = 5'd23
    } phase_t;

    localparam logic [3:0] TK_SEQ    = 4'd0;
    localparam logic [3:0] TK_CTX    = 4'd1;
    localparam logic [3:0] TK_SRX    = 4'd2;
    localparam logic [3:0] TK_STX    = 4'd3;
    localparam logic [3:0] TK_STRLEN = 4'd4;
    localparam logic [3:0] TK_STRB   = 4'd5;
    localparam logic [3:0] TK_ABSENT = 4'd6;
    localparam logic [3:0] TK_FTYPE  = 4'd7;
    localparam logic [3:0] TK_PSIZE  = 4'd8;
    localparam logic [3:0] TK_PBYTE  = 4'd9;
    localparam logic [3:0] TK_ACCEPT = 4'd10;
    localparam logic [3:0] TK_ERROR  = 4'd11;

    localparam logic [3:0] ERR_OK       = 4'd0;
    localparam logic [3:0] ERR_BADLEN   = 4'd1;
    localparam logic [3:0] ERR_SMALL    = 4'd2;
    localparam logic [3:0] ERR_MAGIC    = 4'd3;
    localparam logic [3:0] ERR_VERSION  = 4'd4;
    localparam logic [3:0] ERR_KIND     = 4'd5;
    localparam logic [3:0] ERR_UNDERRUN = 4'd6;
    localparam logic [3:0] ERR_OVERLONG = 4'd7;
    localparam logic [3:0] ERR_TRAILING = 4'd8;

    localparam logic [0:0] CFG_KIND = 1'd0;
    localparam logic [0:0] CFG_MAX  = 1'd1;

    localparam logic [1:0]  KIND_REQ     = 2'd1;
    localparam logic [1:0]  KIND_ACK     = 2'd2;
    localparam logic [15:0] ABSENT_LEN   = 16'hFFFF;
    localparam logic [2:0]  HEADER_BYTES = 3'd6;
    localparam logic [7:0]  PROTO_VER    = 8'd1;
    localparam logic [31:0] MAX_RESET    = 32'd65536;

    // Queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  slot;
        logic [63:0] value;
        logic [3:0]  err;
        logic        last;
    } token_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] r;
        case (pos)
            2'd0:    r = 8'h49;
            2'd1:    r = 8'h35;
            2'd2:    r = 8'h47;
            default: r = 8'h50;
        endcase
        return r;
    endfunction

endpackage

/* rtl/ppsp_front.sv */
// Front part: byte parser that classifies each byte and produces at most one token.
module ppsp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    input  logic [7:0]           byte_data,
    input  logic [1:0]           expected_kind,
    input  logic [31:0]          max_packet_bytes,
    output logic                 tok_valid,
    output ppsp_pkg::token_t     tok
);
    import ppsp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] left_reg, left_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] run_reg, run_next;
    logic        halted_reg, halted_next;

    logic [31:0] left_dec;
    logic        at_end;
    logic [63:0] acc_sh;
    logic [31:0] run_dec;
    logic [15:0] len16;
    logic        emit;
    token_t      t;

    assign left_dec = (left_reg != 32'd0) ? left_reg - 32'd1 : 32'd0;
    assign at_end   = (left_dec == 32'd0);
    assign acc_sh   = {acc_reg[55:0], byte_data};
    assign run_dec  = (run_reg != 32'd0) ? run_reg - 32'd1 : 32'd0;
    assign len16    = acc_sh[15:0];

    // Next state and token for one accepted byte
    always_comb
    begin
        phase_t nx;
        logic   fl;
        logic [3:0] fcode;
        logic   adv;
        logic [3:0] ak;
        logic [1:0] as;
        logic [63:0] av;
        logic   done_ok;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        left_next   = left_reg;
        acc_next    = acc_reg;
        run_next    = run_reg;
        halted_next = halted_reg;
        emit = 1'b0;
        t    = '0;
        nx   = phase_reg;
        fl   = 1'b0;
        fcode = ERR_OK;
        adv  = 1'b0;
        ak   = 4'd0;
        as   = 2'd0;
        av   = 64'd0;
        done_ok = 1'b0;
        if (byte_valid && !halted_reg)
        begin
            if (phase_reg == PH_PREFIX)
            begin
                if (cnt_reg != 3'd3)
                begin
                    acc_next = acc_sh;
                    cnt_next = cnt_reg + 3'd1;
                end
                else
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    if (acc_sh[31:0] == 32'd0 || acc_sh[31:0] > max_packet_bytes)
                    begin
                        halted_next = 1'b1;
                        emit = 1'b1;
                        t = '{TK_ERROR, 2'd0, 64'd0, ERR_BADLEN, 1'b1};
                    end
                    else
                    begin
                        left_next = acc_sh[31:0];
                        if (acc_sh[31:0] < 32'(HEADER_BYTES))
                        begin
                            phase_next = PH_DISCARD;
                            emit = 1'b1;
                            t = '{TK_ERROR, 2'd0, 64'd0, ERR_SMALL, 1'b1};
                        end
                        else
                            phase_next = PH_HDR;
                    end
                end
            end
            else
            begin
                left_next = left_dec;
                case (phase_reg)
                    PH_HDR:
                    begin
                        if (cnt_reg < 3'd4 && byte_data != magic_byte(cnt_reg[1:0]))
                        begin
                            fl = 1'b1; fcode = ERR_MAGIC;
                        end
                        else if (cnt_reg == 3'd4 && byte_data != PROTO_VER)
                        begin
                            fl = 1'b1; fcode = ERR_VERSION;
                        end
                        else if (cnt_reg == 3'd5 && (byte_data != {6'd0, expected_kind}
                                 || (expected_kind != KIND_REQ && expected_kind != KIND_ACK)))
                        begin
                            fl = 1'b1; fcode = ERR_KIND;
                        end
                        else if (cnt_reg != 3'd5)
                            cnt_next = cnt_reg + 3'd1;
                        else
                        begin
                            cnt_next = '0;
                            if (at_end)
                            begin
                                fl = 1'b1; fcode = ERR_UNDERRUN;
                            end
                            else
                                phase_next = (expected_kind == KIND_REQ) ? PH_SEQ_R : PH_SEQ_A;
                        end
                    end
                    PH_SEQ_R, PH_CTX_R, PH_SEQ_A, PH_CTX_A, PH_SRX, PH_STX:
                    begin
                        if (cnt_reg != 3'd7)
                        begin
                            acc_next = acc_sh;
                            cnt_next = cnt_reg + 3'd1;
                            if (at_end)
                            begin
                                fl = 1'b1; fcode = ERR_UNDERRUN;
                            end
                        end
                        else
                        begin
                            acc_next = '0;
                            cnt_next = '0;
                            adv = 1'b1;
                            av = acc_sh;
                            case (phase_reg)
                                PH_SEQ_R: begin ak = TK_SEQ; nx = PH_CTX_R; end
                                PH_CTX_R: begin ak = TK_CTX; nx = PH_LEN0; end
                                PH_SEQ_A: begin ak = TK_SEQ; nx = PH_CTX_A; end
                                PH_CTX_A: begin ak = TK_CTX; nx = PH_SRX; end
                                PH_SRX:   begin ak = TK_SRX; nx = PH_STX; end
                                default:  begin ak = TK_STX; nx = PH_FT_A; end
                            endcase
                        end
                    end
                    PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3:
                    begin
                        case (phase_reg)
                            PH_LEN0: as = 2'd0;
                            PH_LEN1: as = 2'd1;
                            PH_LEN2: as = 2'd2;
                            default: as = 2'd3;
                        endcase
                        if (cnt_reg == 3'd0)
                        begin
                            acc_next = acc_sh;
                            cnt_next = 3'd1;
                            if (at_end)
                            begin
                                fl = 1'b1; fcode = ERR_UNDERRUN;
                            end
                        end
                        else
                        begin
                            acc_next = '0;
                            cnt_next = '0;
                            if (as == 2'd2 && len16 == ABSENT_LEN)
                            begin
                                adv = 1'b1; ak = TK_ABSENT; av = 64'(ABSENT_LEN);
                                nx = PH_FT_R;
                            end
                            else if (32'(len16) > left_dec)
                            begin
                                fl = 1'b1; fcode = ERR_OVERLONG;
                            end
                            else
                            begin
                                adv = 1'b1; ak = TK_STRLEN; av = 64'(len16);
                                if (len16 == 16'd0)
                                begin
                                    case (as)
                                        2'd0:    nx = PH_LEN1;
                                        2'd1:    nx = PH_LEN2;
                                        2'd2:    nx = PH_FT_R;
                                        default: nx = PH_DONE;
                                    endcase
                                end
                                else
                                begin
                                    run_next = 32'(len16);
                                    nx = phase_t'(phase_reg + 5'd1);
                                end
                            end
                        end
                    end
                    PH_STR0, PH_STR1, PH_STR2, PH_STR3:
                    begin
                        case (phase_reg)
                            PH_STR0: as = 2'd0;
                            PH_STR1: as = 2'd1;
                            PH_STR2: as = 2'd2;
                            default: as = 2'd3;
                        endcase
                        run_next = run_dec;
                        adv = 1'b1; ak = TK_STRB; av = 64'(byte_data);
                        if (run_dec != 32'd0)
                            nx = phase_reg;
                        else
                        begin
                            case (as)
                                2'd0:    nx = PH_LEN1;
                                2'd1:    nx = PH_LEN2;
                                2'd2:    nx = PH_FT_R;
                                default: nx = PH_DONE;
                            endcase
                        end
                    end
                    PH_FT_R, PH_FT_A:
                    begin
                        adv = 1'b1; ak = TK_FTYPE; av = 64'(byte_data);
                        nx = (phase_reg == PH_FT_R) ? PH_PS_R : PH_PS_A;
                    end
                    PH_PS_R, PH_PS_A:
                    begin
                        if (cnt_reg != 3'd3)
                        begin
                            acc_next = acc_sh;
                            cnt_next = cnt_reg + 3'd1;
                            if (at_end)
                            begin
                                fl = 1'b1; fcode = ERR_UNDERRUN;
                            end
                        end
                        else
                        begin
                            acc_next = '0;
                            cnt_next = '0;
                            if (phase_reg == PH_PS_A)
                            begin
                                adv = 1'b1; ak = TK_PSIZE; av = 64'(acc_sh[31:0]);
                                nx = PH_ACC;
                            end
                            else if (acc_sh[31:0] > left_dec)
                            begin
                                fl = 1'b1; fcode = ERR_OVERLONG;
                            end
                            else
                            begin
                                adv = 1'b1; ak = TK_PSIZE; av = 64'(acc_sh[31:0]);
                                if (acc_sh[31:0] == 32'd0)
                                    nx = PH_DONE;
                                else
                                begin
                                    run_next = acc_sh[31:0];
                                    nx = PH_PAY;
                                end
                            end
                        end
                    end
                    PH_PAY:
                    begin
                        run_next = run_dec;
                        adv = 1'b1; ak = TK_PBYTE; av = 64'(byte_data);
                        nx = (run_dec == 32'd0) ? PH_DONE : PH_PAY;
                    end
                    PH_ACC:
                    begin
                        adv = 1'b1; ak = TK_ACCEPT; av = {63'd0, byte_data != 8'd0};
                        nx = PH_LEN3;
                    end
                    PH_DONE:
                    begin
                        fl = 1'b1; fcode = ERR_TRAILING;
                    end
                    default:
                        phase_next = at_end ? PH_PREFIX : PH_DISCARD;
                endcase

                // Resolve a completed field against the packet end
                if (adv)
                begin
                    done_ok = (nx == PH_DONE);
                    if (!done_ok && at_end)
                    begin
                        fl = 1'b1; fcode = ERR_UNDERRUN;
                    end
                    else
                    begin
                        phase_next = (done_ok && at_end) ? PH_PREFIX : nx;
                        emit = 1'b1;
                        t = '{ak, as, av, ERR_OK, done_ok && at_end};
                    end
                end
                if (fl)
                begin
                    cnt_next = '0;
                    acc_next = '0;
                    run_next = '0;
                    phase_next = at_end ? PH_PREFIX : PH_DISCARD;
                    emit = 1'b1;
                    t = '{TK_ERROR, 2'd0, 64'd0, fcode, 1'b1};
                end
            end
        end
    end

    assign tok_valid = emit;
    assign tok       = t;

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PREFIX;
            cnt_reg    <= '0;
            left_reg   <= '0;
            acc_reg    <= '0;
            run_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            left_reg   <= left_next;
            acc_reg    <= acc_next;
            run_reg    <= run_next;
            halted_reg <= halted_next;
        end
    end

    // Once halted, the parser never emits again
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !tok_valid)
        else $error("token emitted while halted");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared without reset");
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok.kind == TK_ERROR) |-> (tok.last && tok.err != ERR_OK))
        else $error("error token malformed");

endmodule

/* rtl/ppsp_back.sv */
// Back part: token queue and registered output stage toward the master side.
module ppsp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tok_valid,
    input  ppsp_pkg::token_t     tok,
    output logic                 space_ok,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ppsp_pkg::token_t     out_tok
);
    import ppsp_pkg::*;

    token_t        q_mem [QDEPTH];
    logic [QAW:0]  wr_reg, rd_reg, cnt;
    logic          ov_reg;
    token_t        ot_reg;
    logic          pop;

    assign cnt      = wr_reg - rd_reg;
    // Reserve room for one token per accepted byte; the output register is not counted
    assign space_ok = (cnt != (QAW+1)'(QDEPTH));
    assign pop      = (cnt != '0) && (!ov_reg || out_ready);

    // Write queue entries and load the output register on a pop
    always_ff @(posedge clk)
    begin
        if (tok_valid)
            q_mem[wr_reg[QAW-1:0]] <= tok;
        if (pop)
            ot_reg <= q_mem[rd_reg[QAW-1:0]];
    end

    // Advance pointers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (tok_valid)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (pop)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid = ov_reg;
    assign out_tok   = ot_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> space_ok)
        else $error("queue overflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt <= (QAW+1)'(QDEPTH))
        else $error("queue count out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_tok)))
        else $error("output dropped while stalled");

endmodule

/* rtl/probe_packet_stream_parser.sv */
// Top level: probe packet stream parser with config registers, front parser and token queue.
// A token passes through the token queue and then the output register before it leaves.
// Throughput: one byte per cycle; the four-entry token queue stalls input only
// when it is full behind a stalled master side.
// Reset: rst_n clears parser state, the halt flag, the queue and restores
// expected_kind 1 and max_packet_bytes 65536.
module probe_packet_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [3:0] token_kind, [5:4] string_slot,
                                   // [69:6] token_value, [73:70] error_code, zero fill
    output logic        m_tlast
);
    import ppsp_pkg::*;

    logic [1:0]  kind_reg;
    logic [31:0] max_reg;
    logic        tok_valid, space_ok, ov;
    token_t      tok, ot;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_REQ;
            max_reg  <= MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KIND: kind_reg <= cfg_data[1:0];
                CFG_MAX:  max_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign s_tready = space_ok;

    ppsp_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_valid       (s_tvalid && space_ok),
        .byte_data        (s_tdata),
        .expected_kind    (kind_reg),
        .max_packet_bytes (max_reg),
        .tok_valid        (tok_valid),
        .tok              (tok)
    );

    ppsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .space_ok  (space_ok),
        .out_valid (ov),
        .out_ready (m_tready),
        .out_tok   (ot)
    );

    assign m_tvalid = ov;
    assign m_tdata  = {6'd0, ot.err, ot.value, ot.slot, ot.kind};
    assign m_tlast  = ot.last;

endmodule
